FILE: src/adsf_pkg.sv
// Shared types, constants and helper functions of the distance and speed filter.
package adsf_pkg;

  localparam int DEF_CHANNELS = 4;
  localparam int DEF_ROUNDS   = 10;

  localparam int SAMPLE_W  = 12;
  localparam int CHAN_W    = 2;
  localparam int DATA_W    = 40;   // Q23.16
  localparam int COEF_W    = 32;   // Q1.30
  localparam int ACC_W     = 44;   // three truncated products, exact
  localparam int SAT_IN_W  = 52;
  localparam int NUM_REGS  = 6;
  localparam int REG_IDX_W = 3;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_POS_NOW  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_POS_PREV = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_POS_FB   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPD_NOW  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPD_PREV = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SPD_FB   = 3'd5;

  localparam logic signed [COEF_W-1:0] RST_POS_NOW  = 32'sd1786592;
  localparam logic signed [COEF_W-1:0] RST_POS_PREV = 32'sd1786592;
  localparam logic signed [COEF_W-1:0] RST_POS_FB   = -32'sd1070168640;
  localparam logic signed [COEF_W-1:0] RST_SPD_NOW  = 32'sd10631107;
  localparam logic signed [COEF_W-1:0] RST_SPD_PREV = 32'sd10631107;
  localparam logic signed [COEF_W-1:0] RST_SPD_FB   = -32'sd1052479610;

  // filter term selectors
  localparam logic [1:0] TERM_NOW      = 2'd0;
  localparam logic [1:0] TERM_PREV_IN  = 2'd1;
  localparam logic [1:0] TERM_PREV_OUT = 2'd2;

  localparam int KIND_SAMPLE = 0;
  localparam int KIND_TICK   = 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CH_START,
    ST_SUM,
    ST_SUM_END,
    ST_SCALE,
    ST_MHI,
    ST_MLO,
    ST_MACC,
    ST_POS_DONE,
    ST_SPD_PREP,
    ST_SPD_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic mul_hi;   // product of coefficient and upper data half
    logic mul_lo;   // add product of coefficient and lower data half
    logic acc_clr;
    logic acc_add;
    logic acc_sub;
  } mac_ctl_t;

  function automatic logic signed [DATA_W-1:0] sat40(input logic signed [SAT_IN_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[SAT_IN_W-1:DATA_W-1] == '0 || v[SAT_IN_W-1:DATA_W-1] == '1) begin
      r = v[DATA_W-1:0];
    end else if (v[SAT_IN_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: src/adsf_if.sv
// Valid/ready channel interfaces for input items and result items.
interface adsf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [adsf_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, kind, sample, input ready);
  modport sink   (input valid, kind, sample, output ready);
endinterface

interface adsf_out_if;
  logic                               valid;
  logic                               ready;
  logic [adsf_pkg::CHAN_W-1:0]        channel;
  logic signed [adsf_pkg::DATA_W-1:0] distance;
  logic signed [adsf_pkg::DATA_W-1:0] speed;
  logic                               last;

  modport source (output valid, channel, distance, speed, last, input ready);
  modport sink   (input valid, channel, distance, speed, last, output ready);
endinterface

FILE: src/adsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module adsf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 40,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/adsf_window.sv
// Circular sample window: RAM, write slot and fill tracking.
module adsf_window #(
  parameter int DEPTH = 40,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [adsf_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [adsf_pkg::SAMPLE_W-1:0] rd_data
);
  import adsf_pkg::*;

  logic [AW-1:0]       slot_r;
  logic                full_r;
  logic                vld_r;
  logic [SAMPLE_W-1:0] ram_q;

  // slots fill from zero upward, so never-written entries lie at or above slot_r until wrap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      full_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        if (slot_r == AW'(DEPTH - 1)) begin
          slot_r <= '0;
          full_r <= 1'b1;
        end else begin
          slot_r <= slot_r + AW'(1);
        end
      end
      if (rd_en) begin
        vld_r <= full_r || (rd_addr < slot_r);
      end
    end
  end

  adsf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (slot_r),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  assign rd_data = vld_r ? ram_q : '0;

endmodule

FILE: src/adsf_mac.sv
// Shared multiply-accumulate unit: 32x21 multiplier, Q30 truncation, 44-bit accumulator.
module adsf_mac (
  input  logic                               clk,
  input  adsf_pkg::mac_ctl_t                 ctl,
  input  logic signed [adsf_pkg::COEF_W-1:0] coef,
  input  logic signed [adsf_pkg::DATA_W-1:0] data,
  output logic signed [adsf_pkg::ACC_W-1:0]  acc
);
  import adsf_pkg::*;

  localparam int HALF_W = DATA_W / 2;
  localparam int PROD_W = COEF_W + HALF_W + 1;
  localparam int PART_W = PROD_W + HALF_W;
  localparam int TERM_W = PART_W - 30;

  logic signed [HALF_W:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PART_W-1:0] part_r;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc_r;

  // upper half signed, lower half unsigned: data = hi*2^20 + lo
  assign mul_b = ctl.mul_hi ? {data[DATA_W-1], data[DATA_W-1:HALF_W]}
                            : {1'b0, data[HALF_W-1:0]};
  assign prod  = coef * mul_b;
  // floor(coef*data / 2^30)
  assign term  = part_r[PART_W-1:30];

  always_ff @(posedge clk) begin
    if (ctl.mul_hi) begin
      part_r <= {prod, {HALF_W{1'b0}}};
    end else if (ctl.mul_lo) begin
      part_r <= part_r + PART_W'(prod);
    end
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (ctl.acc_add) begin
      acc_r <= acc_r + ACC_W'(term);
    end else if (ctl.acc_sub) begin
      acc_r <= acc_r - ACC_W'(term);
    end
  end

  assign acc = acc_r;

endmodule

FILE: src/adc_distance_speed_filter.sv
// Top level of the converter distance and speed filter.
// Usage: a sample item (kind 0) is written into the circular window of
// CHANNELS*ROUNDS entries in scan order and is taken with no result, the
// block staying ready for the next item. A tick item (kind 1) runs every
// channel in turn through one shared multiply-accumulate unit: ROUNDS window
// reads (one RAM read port) to sum the channel, a scale to Q23.16, three
// coefficient terms for the position filter, the speed difference times
// 1000, and three terms for the speed filter. Each term passes the 32x21
// multiplier in the steps upper data half, lower data half, truncate and
// accumulate. A tick holds the block until its final result is taken,
// longer when the result side stalls. Results come in channel order, last
// set on the final one. in ready is low for the whole tick. Registers must
// be written through the cfg port only while no tick is in progress; the
// block itself does not enforce this. An index above five is ignored.
// Never-written window entries read as zero, tracked by the write slot and a
// wrap flag, so no clearing pass is needed after reset.
module adc_distance_speed_filter #(
  parameter int CHANNELS = adsf_pkg::DEF_CHANNELS,
  parameter int ROUNDS   = adsf_pkg::DEF_ROUNDS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  adsf_in_if.sink                         in_chan,
  adsf_out_if.source                      out_chan,
  input  logic                            cfg_wr_en,
  input  logic [adsf_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [adsf_pkg::COEF_W-1:0]     cfg_data
);
  import adsf_pkg::*;

  localparam int WIN   = CHANNELS * ROUNDS;
  localparam int AW    = (WIN > 1) ? $clog2(WIN) : 1;
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RD_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int SUM_W = $clog2(ROUNDS) + SAMPLE_W;
  localparam int DIF_W = DATA_W + 1;
  localparam int SPM_W = DIF_W + 10;

  // sequencer
  state_t state_r, state_nxt;
  logic   in_acc, out_acc;
  logic   win_we, rd_en;
  mac_ctl_t mac_ctl;

  logic [CH_W-1:0]  ch_r;
  logic [1:0]       term_r;
  logic             spd_r;      // 0: position filter, 1: speed filter
  logic [RD_W-1:0]  rd_cnt_r;
  logic [AW-1:0]    ptr_r;
  logic             pend_r;

  // datapath
  logic [SAMPLE_W-1:0]      rd_data;
  logic [SUM_W-1:0]         sum_r;
  logic signed [DATA_W-1:0] x_r;
  logic signed [DATA_W-1:0] dist_r;
  logic signed [DATA_W-1:0] prev_dist_r;
  logic signed [DATA_W-1:0] pos_pin_r  [CHANNELS];
  logic signed [DATA_W-1:0] pos_pout_r [CHANNELS];
  logic signed [DATA_W-1:0] spd_pin_r  [CHANNELS];
  logic signed [DATA_W-1:0] spd_pout_r [CHANNELS];
  logic signed [COEF_W-1:0] cfg_r      [NUM_REGS];

  logic [REG_IDX_W-1:0]     coef_idx;
  logic signed [COEF_W-1:0] coef;
  logic signed [DATA_W-1:0] mac_data;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DATA_W-1:0] acc_sat;
  logic signed [DATA_W-1:0] scaled;
  logic signed [DIF_W-1:0]  dist_diff;
  logic signed [SPM_W-1:0]  diff_x1000;
  logic signed [DATA_W-1:0] raw_speed;

  logic [CHAN_W-1:0]        out_channel_r;
  logic signed [DATA_W-1:0] out_distance_r;
  logic signed [DATA_W-1:0] out_speed_r;
  logic                     out_last_r;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_acc && in_chan.kind == 1'(KIND_TICK)) state_nxt = ST_CH_START;
      ST_CH_START: state_nxt = ST_SUM;
      ST_SUM:      if (rd_cnt_r == RD_W'(ROUNDS - 1)) state_nxt = ST_SUM_END;
      ST_SUM_END:  state_nxt = ST_SCALE;
      ST_SCALE:    state_nxt = ST_MHI;
      ST_MHI:      state_nxt = ST_MLO;
      ST_MLO:      state_nxt = ST_MACC;
      ST_MACC: begin
        if (term_r == TERM_PREV_OUT) begin
          state_nxt = spd_r ? ST_SPD_DONE : ST_POS_DONE;
        end else begin
          state_nxt = ST_MHI;
        end
      end
      ST_POS_DONE: state_nxt = ST_SPD_PREP;
      ST_SPD_PREP: state_nxt = ST_MHI;
      ST_SPD_DONE: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_acc) begin
          state_nxt = (ch_r == CH_W'(CHANNELS - 1)) ? ST_IDLE : ST_CH_START;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mac_ctl         = '0;
    win_we          = 1'b0;
    rd_en           = 1'b0;
    in_chan.ready   = 1'b0;
    out_chan.valid  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // ready is high here, so valid alone marks a transfer
        in_chan.ready = 1'b1;
        win_we        = in_chan.valid && in_chan.kind == 1'(KIND_SAMPLE);
      end
      ST_SUM:      rd_en = 1'b1;
      ST_SCALE:    mac_ctl.acc_clr = 1'b1;
      ST_SPD_PREP: mac_ctl.acc_clr = 1'b1;
      ST_MHI:      mac_ctl.mul_hi = 1'b1;
      ST_MLO:      mac_ctl.mul_lo = 1'b1;
      ST_MACC: begin
        // feedback term is subtracted
        mac_ctl.acc_sub = (term_r == TERM_PREV_OUT);
        mac_ctl.acc_add = (term_r != TERM_PREV_OUT);
      end
      ST_OUT:      out_chan.valid = 1'b1;
      default: ;
    endcase
  end

  adsf_window #(
    .DEPTH (WIN),
    .AW    (AW)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (win_we),
    .wr_data (in_chan.sample),
    .rd_en   (rd_en),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  // operand selection for the shared unit
  assign coef_idx = spd_r ? (REG_SPD_NOW + REG_IDX_W'(term_r))
                          : (REG_POS_NOW + REG_IDX_W'(term_r));
  assign coef     = cfg_r[coef_idx];

  always_comb begin
    case (term_r)
      TERM_NOW:     mac_data = x_r;
      TERM_PREV_IN: mac_data = spd_r ? spd_pin_r[ch_r] : pos_pin_r[ch_r];
      default:      mac_data = spd_r ? spd_pout_r[ch_r] : pos_pout_r[ch_r];
    endcase
  end

  adsf_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .coef (coef),
    .data (mac_data),
    .acc  (acc)
  );

  assign acc_sat = sat40(SAT_IN_W'(acc));
  // sum * 15/2048 mm in Q16 is sum * 480
  assign scaled  = DATA_W'({sum_r, 9'b0}) - DATA_W'({sum_r, 5'b0});
  // x1000 = x1024 - x16 - x8
  assign dist_diff  = DIF_W'(dist_r) - DIF_W'(prev_dist_r);
  assign diff_x1000 = (SPM_W'(dist_diff) <<< 10) - (SPM_W'(dist_diff) <<< 4)
                    - (SPM_W'(dist_diff) <<< 3);
  assign raw_speed  = sat40(SAT_IN_W'(diff_x1000));

  // control state and filter history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ch_r     <= '0;
      term_r   <= TERM_NOW;
      spd_r    <= 1'b0;
      rd_cnt_r <= '0;
      ptr_r    <= '0;
      pend_r   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        pos_pin_r[i]  <= '0;
        pos_pout_r[i] <= '0;
        spd_pin_r[i]  <= '0;
        spd_pout_r[i] <= '0;
      end
      cfg_r[REG_POS_NOW]  <= RST_POS_NOW;
      cfg_r[REG_POS_PREV] <= RST_POS_PREV;
      cfg_r[REG_POS_FB]   <= RST_POS_FB;
      cfg_r[REG_SPD_NOW]  <= RST_SPD_NOW;
      cfg_r[REG_SPD_PREV] <= RST_SPD_PREV;
      cfg_r[REG_SPD_FB]   <= RST_SPD_FB;
    end else begin
      state_r <= state_nxt;
      pend_r  <= rd_en;
      if (cfg_wr_en && cfg_index < REG_IDX_W'(NUM_REGS)) begin
        cfg_r[cfg_index] <= cfg_data;
      end
      unique case (state_r)
        ST_IDLE: begin
          ch_r <= '0;
        end
        ST_CH_START: begin
          rd_cnt_r <= '0;
          ptr_r    <= AW'(ch_r);
        end
        ST_SUM: begin
          rd_cnt_r <= rd_cnt_r + RD_W'(1);
          ptr_r    <= ptr_r + AW'(CHANNELS);
        end
        ST_SCALE: begin
          term_r <= TERM_NOW;
          spd_r  <= 1'b0;
        end
        ST_MACC: begin
          if (term_r != TERM_PREV_OUT) begin
            term_r <= term_r + 2'd1;
          end
        end
        ST_POS_DONE: begin
          pos_pin_r[ch_r]  <= x_r;
          pos_pout_r[ch_r] <= acc_sat;
        end
        ST_SPD_PREP: begin
          term_r <= TERM_NOW;
          spd_r  <= 1'b1;
        end
        ST_SPD_DONE: begin
          spd_pin_r[ch_r]  <= x_r;
          spd_pout_r[ch_r] <= acc_sat;
        end
        ST_OUT: begin
          if (out_acc && ch_r != CH_W'(CHANNELS - 1)) begin
            ch_r <= ch_r + CH_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_CH_START) begin
      sum_r <= '0;
    end else if (pend_r) begin
      sum_r <= sum_r + SUM_W'(rd_data);
    end
    case (state_r)
      ST_SCALE:    x_r <= scaled;
      ST_POS_DONE: begin
        dist_r      <= acc_sat;
        prev_dist_r <= pos_pout_r[ch_r];
      end
      ST_SPD_PREP: x_r <= raw_speed;
      ST_SPD_DONE: begin
        out_channel_r  <= CHAN_W'(ch_r);
        out_distance_r <= dist_r;
        out_speed_r    <= acc_sat;
        out_last_r     <= (ch_r == CH_W'(CHANNELS - 1));
      end
      default: ;
    endcase
  end

  assign out_chan.channel  = out_channel_r;
  assign out_chan.distance = out_distance_r;
  assign out_chan.speed    = out_speed_r;
  assign out_chan.last     = out_last_r;

endmodule

FILE: src/adsf_chk.sv
// Port-level checker for the distance and speed filter, bound to the top level.
module adsf_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_kind,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_last,
  input logic signed [adsf_pkg::DATA_W-1:0] out_distance
);
  import adsf_pkg::*;

  // no input transfer while a result is offered
  a_ready_vs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // a tick blocks the input side
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == 1'(KIND_TICK)) |=> !in_ready)
    else $error("input ready right after tick transfer");

  // the block is still ready after a sample transfer
  a_sample_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == 1'(KIND_SAMPLE)) |=> in_ready)
    else $error("block busy after sample transfer");

  // more results follow a result that is not last
  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> !in_ready)
    else $error("input ready before last result");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_distance)))
    else $error("stalled result changed");

endmodule

bind adc_distance_speed_filter adsf_chk u_adsf_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_kind      (in_chan.kind),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_last     (out_chan.last),
  .out_distance (out_chan.distance)
);

FILE: verif/adc_distance_speed_filter_test.sv
// Self-checking testbench for the converter distance and speed filter.
module adc_distance_speed_filter_test;
  import adsf_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 9;
  localparam int MAX_WAIT       = 12;
  localparam int WINDOW_LEN     = DEF_CHANNELS * DEF_ROUNDS;
  localparam int MM_SCALE       = 480;    // 15/2048 mm per count, in Q23.16
  localparam int SPEED_GAIN     = 1000;   // mm per tick to mm/s
  localparam int PHASE_ITEMS    = 35;
  localparam int SETTLE_CYCLES  = 16;     // tick wind-down before a register write
  localparam int DRAIN_CYCLES   = 160;    // a bit more than one full tick
  localparam int TIMEOUT_CYCLES = 500000;

  localparam longint Q40_MAX = 64'sd549755813887;
  localparam longint Q40_MIN = -64'sd549755813888;

  // writes to these must leave every register alone
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef logic signed [DATA_W-1:0] q40_t;
  typedef logic signed [COEF_W-1:0] q30_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    q40_t              distance;
    q40_t              speed;
    logic              last;
  } reading_t;

  // Tracks the filter state, predicts the four readings of every tick and
  // checks them in order against what comes out of the block.
  class reading_scoreboard;
    q30_t              gain [NUM_REGS];
    logic [SAMPLE_W-1:0] window [WINDOW_LEN];
    int                slot;
    q40_t              pos_in  [DEF_CHANNELS];
    q40_t              pos_out [DEF_CHANNELS];
    q40_t              spd_in  [DEF_CHANNELS];
    q40_t              spd_out [DEF_CHANNELS];
    reading_t          pending_readings [$];
    int                errors;

    function new();
      gain[REG_POS_NOW]  = RST_POS_NOW;
      gain[REG_POS_PREV] = RST_POS_PREV;
      gain[REG_POS_FB]   = RST_POS_FB;
      gain[REG_SPD_NOW]  = RST_SPD_NOW;
      gain[REG_SPD_PREV] = RST_SPD_PREV;
      gain[REG_SPD_FB]   = RST_SPD_FB;
      foreach (window[i]) window[i] = '0;
      foreach (pos_in[c]) begin
        pos_in[c]  = '0;
        pos_out[c] = '0;
        spd_in[c]  = '0;
        spd_out[c] = '0;
      end
      slot   = 0;
      errors = 0;
    endfunction

    function void write_gain(logic [REG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
      if (idx < NUM_REGS) gain[idx] = value;
    endfunction

    function q40_t clamp_q40(longint v);
      q40_t r;
      if (v > Q40_MAX) v = Q40_MAX;
      else if (v < Q40_MIN) v = Q40_MIN;
      r = DATA_W'(v);
      return r;
    endfunction

    // coefficient times data, exact, then floor by 30 fraction bits
    function longint q30_term(q30_t k, q40_t d);
      logic signed [COEF_W+DATA_W-1:0] p;
      p = k * d;
      p = p >>> 30;
      return 64'(p);
    endfunction

    function q40_t iir_update(input q40_t x, inout q40_t prev_in, inout q40_t prev_out,
                              input q30_t k_now, input q30_t k_prev, input q30_t k_fb);
      longint acc;
      q40_t   y;
      acc = q30_term(k_now, x) + q30_term(k_prev, prev_in) - q30_term(k_fb, prev_out);
      y = clamp_q40(acc);
      prev_in  = x;
      prev_out = y;
      return y;
    endfunction

    function void run_tick();
      int     total;
      q40_t   level;
      q40_t   dist_now;
      q40_t   last_dist;
      q40_t   speed;
      longint delta;
      for (int c = 0; c < DEF_CHANNELS; c++) begin
        total = 0;
        for (int r = 0; r < DEF_ROUNDS; r++) total += window[c + r * DEF_CHANNELS];
        level     = DATA_W'(total * MM_SCALE);
        last_dist = pos_out[c];
        dist_now = iir_update(level, pos_in[c], pos_out[c],
                              gain[REG_POS_NOW], gain[REG_POS_PREV], gain[REG_POS_FB]);
        delta = 64'(dist_now);
        delta = (delta - last_dist) * SPEED_GAIN;
        speed = iir_update(clamp_q40(delta), spd_in[c], spd_out[c],
                           gain[REG_SPD_NOW], gain[REG_SPD_PREV], gain[REG_SPD_FB]);
        pending_readings.push_back('{channel: CHAN_W'(c), distance: dist_now, speed: speed,
                                     last: (c == DEF_CHANNELS - 1)});
      end
    endfunction

    function void take_item(logic kind, logic [SAMPLE_W-1:0] value);
      if (kind == KIND_TICK) begin
        run_tick();
      end else begin
        window[slot] = value;
        slot = (slot + 1) % WINDOW_LEN;
      end
    endfunction

    function void compare_field(string field, q40_t want, q40_t got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (pending_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual ch %0d dist %0d spd %0d last %0b",
                 $time, got.channel, got.distance, got.speed, got.last);
        return;
      end
      want = pending_readings.pop_front();
      compare_field("channel", want.channel, got.channel);
      compare_field("distance", want.distance, got.distance);
      compare_field("speed", want.speed, got.speed);
      compare_field("last", want.last, got.last);
    endfunction

    function int waiting();
      return pending_readings.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  adsf_in_if  in_if ();
  adsf_out_if out_if ();

  reading_scoreboard book;
  int in_calm  = 0;   // transfers left in a no-gap stretch, sender side
  int out_calm = 0;   // same for the result side

  adc_distance_speed_filter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Per-transfer wait: mostly 0..MAX_WAIT, now and then a run of zero waits
  // so back-to-back transfers also get exercised.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Converter values lean on the rails so full-scale sums show up often.
  function automatic logic [SAMPLE_W-1:0] draw_sample();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
  endfunction

  // One input transfer. valid stays up between back-to-back items, so it
  // only gets one assignment per edge.
  task automatic send_item(input logic kind, input logic [SAMPLE_W-1:0] value);
    int gap;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.kind   <= kind;
    in_if.sample <= value;
    do @(posedge clk); while (!in_if.ready);
    book.take_item(kind, value);
  endtask

  // Drop valid, wait for every predicted reading, then let the block wind down.
  task automatic settle(input int cycles);
    in_if.valid <= 1'b0;
    while (book.waiting() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_gain(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    book.write_gain(idx, value);
  endtask

  // Full register load, bracketed by writes to the two unused indexes.
  task automatic load_gains(input q30_t gains [NUM_REGS]);
    write_gain(REG_SPARE_LO, $urandom());
    for (int i = 0; i < NUM_REGS; i++) write_gain(REG_IDX_W'(i), gains[i]);
    write_gain(REG_SPARE_HI, $urandom());
    cfg_wr_en <= 1'b0;
  endtask

  // Bursts of samples closed by a tick. Short bursts only refresh part of
  // the window; long ones wrap it once or more.
  task automatic random_phase();
    int sent;
    int burst;
    int pick;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) burst = $urandom_range(0, 8);
      else if (pick < 9) burst = $urandom_range(30, 44);
      else burst = $urandom_range(45, 90);
      repeat (burst) send_item(1'(KIND_SAMPLE), draw_sample());
      send_item(1'(KIND_TICK), draw_sample());
      sent += burst + 1;
    end
  endtask

  // Result side: random stalls on ready, check at every transfer.
  initial begin
    int       stall;
    reading_t got;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_wait(out_calm);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got.channel  = out_if.channel;
      got.distance = out_if.distance;
      got.speed    = out_if.speed;
      got.last     = out_if.last;
      book.check_reading(got);
    end
  end

  initial begin
    q30_t gains [NUM_REGS];
    book = new();
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_if.valid  <= 1'b0;
    in_if.kind   <= 1'b0;
    in_if.sample <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: tick on an empty window, a partly filled window at full
    // scale, a repeated tick on unchanged samples, then small, mid and near full-scale values.
    send_item(1'(KIND_TICK), '0);
    repeat (12) send_item(1'(KIND_SAMPLE), '1);
    send_item(1'(KIND_TICK), '1);
    send_item(1'(KIND_TICK), 12'h555);
    send_item(1'(KIND_SAMPLE), 12'h000);
    send_item(1'(KIND_SAMPLE), 12'h001);
    send_item(1'(KIND_SAMPLE), 12'h800);
    send_item(1'(KIND_SAMPLE), 12'h7FF);
    send_item(1'(KIND_SAMPLE), 12'hFFE);
    send_item(1'(KIND_TICK), 12'hAAA);

    // reset gains
    random_phase();
    settle(SETTLE_CYCLES);

    // largest positive gains: output grows until it saturates
    foreach (gains[i]) gains[i] = 32'h7FFF_FFFF;
    load_gains(gains);
    random_phase();
    settle(SETTLE_CYCLES);

    // most negative gains: feedback adds, runs to the rails fast
    foreach (gains[i]) gains[i] = 32'h8000_0000;
    load_gains(gains);
    random_phase();
    settle(SETTLE_CYCLES);

    // all zero: both filters output zero
    foreach (gains[i]) gains[i] = '0;
    load_gains(gains);
    random_phase();
    settle(SETTLE_CYCLES);

    // unity on the current input only: filters pass straight through
    foreach (gains[i]) gains[i] = '0;
    gains[REG_POS_NOW] = 32'h4000_0000;
    gains[REG_SPD_NOW] = 32'h4000_0000;
    load_gains(gains);
    random_phase();
    settle(SETTLE_CYCLES);

    // arbitrary gains
    foreach (gains[i]) gains[i] = $urandom();
    load_gains(gains);
    random_phase();
    settle(SETTLE_CYCLES);

    // back to the stable low-pass set, filters recover from whatever came before
    gains[REG_POS_NOW]  = RST_POS_NOW;
    gains[REG_POS_PREV] = RST_POS_PREV;
    gains[REG_POS_FB]   = RST_POS_FB;
    gains[REG_SPD_NOW]  = RST_SPD_NOW;
    gains[REG_SPD_PREV] = RST_SPD_PREV;
    gains[REG_SPD_FB]   = RST_SPD_FB;
    load_gains(gains);
    random_phase();

    settle(DRAIN_CYCLES);
    if (book.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("simulation failed");
    $finish;
  end

endmodule
